/* src/vse_pkg.sv */
// Package: shared types, constants and state encoding for the similarity engine.
`timescale 1ns / 1ps
`default_nettype none
package vse_pkg;

   localparam int MaxLenDefault   = 1024;
   localparam int ElemBitsDefault = 16;
   localparam int ValueBits       = 41;
   localparam int AccBits         = 42;
   localparam int NormBits        = 41;
   localparam int RootBits        = 21;
   localparam int FracBits        = 15;

   localparam logic [1:0] METRIC_DOT    = 2'd0;
   localparam logic [1:0] METRIC_EUCLID = 2'd1;
   localparam logic [1:0] METRIC_COSINE = 2'd2;
   localparam logic [1:0] METRIC_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [ElemBitsDefault-1:0] elem_a;
      logic signed [ElemBitsDefault-1:0] elem_b;
      logic                              last_pair;
   } req_payload_type;

   typedef struct packed {
      logic signed [ValueBits-1:0] value;
      logic                        zero_norm;
      logic                        too_long;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_SQRT_START,
      ST_SQRT_RUN,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accum;       // add the products of the accepted pair
      logic load_sqrt;   // load the two radicands into the root unit
      logic sqrt_step;   // one root iteration
      logic load_mul;    // register root product and load divider
      logic div_step;    // one divide iteration
      logic finish;      // build the result beat and clear the sums
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sqrt_done;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

/* src/vse_ctrl.sv */
// Controller: sequences accumulate, root, divide and output phases.
`timescale 1ns / 1ps
`default_nettype none
module vse_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_last,
   input  wire logic               rsp_ready,
   input  wire logic [1:0]         metric,
   input  wire vse_pkg::status_type status,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output vse_pkg::cmd_type        cmd
);
   import vse_pkg::*;

   state_type state_ff, state_in;
   logic      fire;

   assign fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (fire && req_last) begin
               if (metric == METRIC_EUCLID || metric == METRIC_COSINE) begin
                  state_in = ST_SQRT_START;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SQRT_START: state_in = ST_SQRT_RUN;
         ST_SQRT_RUN: begin
            if (status.sqrt_done) begin
               state_in = (metric == METRIC_COSINE) ? ST_DIV_START : ST_FINISH;
            end
         end
         ST_DIV_START: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (rsp_ready) state_in = ST_ACCUM;
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            cmd.accum = fire;
         end
         ST_SQRT_START: cmd.load_sqrt = 1'b1;
         ST_SQRT_RUN:   cmd.sqrt_step = 1'b1;
         ST_DIV_START:  cmd.load_mul  = 1'b1;
         ST_DIV_RUN:    cmd.div_step  = 1'b1;
         ST_FINISH:     cmd.finish    = 1'b1;
         ST_OUTPUT:     rsp_valid     = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* src/vse_datapath.sv */
// Datapath: accumulators, shared-step square roots, restoring divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module vse_datapath #(
   parameter int MAX_LEN   = vse_pkg::MaxLenDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [vse_pkg::ElemBitsDefault-1:0] elem_a,
   input  wire logic signed [vse_pkg::ElemBitsDefault-1:0] elem_b,
   input  wire logic [1:0]               metric,
   input  wire vse_pkg::cmd_type         cmd,
   output vse_pkg::status_type           status,
   output vse_pkg::rsp_payload_type      rsp_payload
);
   import vse_pkg::*;

   localparam int ElemBits  = ElemBitsDefault;
   localparam int CntBits   = $clog2(MAX_LEN + 1);
   localparam int SqIters   = RootBits;          // two radicand bits per step
   localparam int SqCntBits = $clog2(SqIters + 1);
   localparam int NumBits   = AccBits + FracBits; // |dot| << 15
   localparam int DenBits   = 2 * RootBits;
   localparam int DivCntBits = $clog2(NumBits + 1);

   // ---------------- accumulation ----------------
   logic signed [AccBits-1:0]  dot_ff, dot_in;
   logic        [AccBits-1:0]  dsq_ff, dsq_in;
   logic        [NormBits-1:0] na_ff, na_in, nb_ff, nb_in;
   logic        [CntBits-1:0]  cnt_ff, cnt_in;
   logic                       ovf_ff, ovf_in;

   logic signed [ElemBits:0]     diff;
   logic signed [2*ElemBits-1:0] prod_ab, prod_aa, prod_bb;
   logic signed [2*ElemBits+1:0] prod_dd;
   logic                         room;

   assign diff    = (ElemBits+1)'(elem_a) - (ElemBits+1)'(elem_b);
   assign prod_ab = elem_a * elem_b;
   assign prod_aa = elem_a * elem_a;
   assign prod_bb = elem_b * elem_b;
   assign prod_dd = diff * diff;
   assign room    = cnt_ff < CntBits'(MAX_LEN);

   always_comb begin
      dot_in = dot_ff;
      dsq_in = dsq_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.accum) begin
         if (room) begin
            dot_in = dot_ff + AccBits'(prod_ab);
            dsq_in = dsq_ff + AccBits'($unsigned(prod_dd));
            na_in  = na_ff + NormBits'($unsigned(prod_aa));
            nb_in  = nb_ff + NormBits'($unsigned(prod_bb));
            cnt_in = cnt_ff + CntBits'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         dot_in = '0;
         dsq_in = '0;
         na_in  = '0;
         nb_in  = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         dsq_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         dot_ff <= dot_in;
         dsq_ff <= dsq_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   // ---------------- square roots: one bit pair per cycle, two lanes ----------------
   // Lane 0 the squared difference (or norm a), lane 1 norm b.
   logic [AccBits-1:0]  rad_ff [2], rad_in [2];
   logic [RootBits-1:0] root_ff [2], root_in [2];
   logic [RootBits+1:0] rem_ff [2], rem_in [2];
   logic [SqCntBits-1:0] sq_cnt_ff, sq_cnt_in;

   always_comb begin
      logic [RootBits+1:0] trial;
      logic [RootBits+1:0] cur;
      for (int l = 0; l < 2; l++) begin
         rad_in[l]  = rad_ff[l];
         root_in[l] = root_ff[l];
         rem_in[l]  = rem_ff[l];
         cur   = {rem_ff[l][RootBits-1:0], rad_ff[l][AccBits-1 -: 2]};
         trial = {root_ff[l], 2'b01};
         if (cmd.sqrt_step) begin
            rad_in[l] = {rad_ff[l][AccBits-3:0], 2'b00};
            if (cur >= trial) begin
               rem_in[l]  = cur - trial;
               root_in[l] = {root_ff[l][RootBits-2:0], 1'b1};
            end else begin
               rem_in[l]  = cur;
               root_in[l] = {root_ff[l][RootBits-2:0], 1'b0};
            end
         end
      end
      if (cmd.load_sqrt) begin
         rad_in[0]  = (metric == METRIC_EUCLID) ? dsq_ff : AccBits'(na_ff);
         rad_in[1]  = AccBits'(nb_ff);
         root_in[0] = '0;
         root_in[1] = '0;
         rem_in[0]  = '0;
         rem_in[1]  = '0;
      end
   end

   assign sq_cnt_in = cmd.load_sqrt ? '0 :
                      cmd.sqrt_step ? sq_cnt_ff + SqCntBits'(1) : sq_cnt_ff;
   assign status.sqrt_done = cmd.sqrt_step && (sq_cnt_ff == SqCntBits'(SqIters - 1));

   always_ff @(posedge clock) begin
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      sq_cnt_ff <= sq_cnt_in;
   end

   // ---------------- cosine divide: restoring, one quotient bit per cycle ----------------
   logic [DenBits-1:0]    den_ff, den_in;
   logic [NumBits-1:0]    num_ff, num_in;
   logic [DenBits:0]      prem_ff, prem_in;
   logic [DivCntBits-1:0] dv_cnt_ff, dv_cnt_in;
   logic                  neg_ff, neg_in;
   logic [AccBits-1:0]    mag;
   logic [DenBits:0]      pcur;

   assign mag  = dot_ff[AccBits-1] ? AccBits'(-dot_ff) : AccBits'(dot_ff);
   assign pcur = {prem_ff[DenBits-1:0], num_ff[NumBits-1]};

   always_comb begin
      den_in  = den_ff;
      num_in  = num_ff;
      prem_in = prem_ff;
      neg_in  = neg_ff;
      if (cmd.load_mul) begin
         den_in  = root_ff[0] * root_ff[1];
         num_in  = {mag, FracBits'(0)};
         prem_in = '0;
         neg_in  = dot_ff[AccBits-1];
      end else if (cmd.div_step) begin
         if (pcur >= {1'b0, den_ff}) begin
            prem_in = pcur - {1'b0, den_ff};
            num_in  = {num_ff[NumBits-2:0], 1'b1};
         end else begin
            prem_in = pcur;
            num_in  = {num_ff[NumBits-2:0], 1'b0};
         end
      end
   end

   assign dv_cnt_in = cmd.load_mul ? '0 :
                      cmd.div_step ? dv_cnt_ff + DivCntBits'(1) : dv_cnt_ff;
   assign status.div_done = cmd.div_step && (dv_cnt_ff == DivCntBits'(NumBits - 1));

   always_ff @(posedge clock) begin
      den_ff    <= den_in;
      num_ff    <= num_in;
      prem_ff   <= prem_in;
      neg_ff    <= neg_in;
      dv_cnt_ff <= dv_cnt_in;
   end

   // ---------------- result beat ----------------
   rsp_payload_type out_ff, out_in;
   logic signed [ValueBits-1:0] dot_sat, cos_val;
   logic                        big;

   always_comb begin
      if (dot_ff > AccBits'(signed'({2'b00, {(ValueBits-1){1'b1}}})))
         dot_sat = {1'b0, {(ValueBits-1){1'b1}}};
      else if (dot_ff < -(AccBits'(signed'({2'b01, {(ValueBits-1){1'b0}}}))))
         dot_sat = {1'b1, {(ValueBits-1){1'b0}}};
      else
         dot_sat = ValueBits'(dot_ff);
      // quotient now sits in num_ff
      big = |num_ff[NumBits-1:FracBits+1];
      if (neg_ff) begin
         if (big || num_ff[FracBits:0] > (FracBits+1)'(32768))
            cos_val = -ValueBits'(32768);
         else
            cos_val = -ValueBits'(num_ff[FracBits:0]);
      end else begin
         if (big || num_ff[FracBits:0] > (FracBits+1)'(32767))
            cos_val = ValueBits'(32767);
         else
            cos_val = ValueBits'(num_ff[FracBits:0]);
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.finish) begin
         out_in.too_long  = ovf_ff;
         out_in.zero_norm = 1'b0;
         case (metric)
            METRIC_DOT:    out_in.value = dot_sat;
            METRIC_EUCLID: out_in.value = ValueBits'(root_ff[0]);
            METRIC_COSINE: begin
               if (na_ff == '0 || nb_ff == '0) begin
                  out_in.value     = '0;
                  out_in.zero_norm = 1'b1;
               end else begin
                  out_in.value = cos_val;
               end
            end
            default: out_in.value = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

/* src/vector_similarity_engine_top.sv */
// Top level of the vector similarity engine: handshakes, metric register, assertions.
`timescale 1ns / 1ps
`default_nettype none
// Element pairs stream in one beat per cycle while req_ready is high and are
// summed into dot product, squared difference and both squared norms. A beat
// with last_pair set ends the vector: the dot metric answers through the finish
// and output states; Euclidean distance runs a 21-step bit-pair square root;
// cosine adds a 57-step restoring divide. Those root and divide units set the
// end-of-vector stall. Pairs past MAX_LEN are dropped and reported through
// too_long. Write csr_write_data only
// while the engine is idle.
module vector_similarity_engine_top #(
   parameter int MAX_LEN   = vse_pkg::MaxLenDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire vse_pkg::req_payload_type  req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output vse_pkg::rsp_payload_type       rsp_payload,
   input  wire logic                      csr_write_enable,
   input  wire logic [1:0]                csr_write_data
);
   import vse_pkg::*;

   logic [1:0] metric_ff;
   cmd_type    cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_DOT;
      end else if (csr_write_enable) begin
         metric_ff <= csr_write_data;
      end
   end

   vse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_pair),
      .rsp_ready (rsp_ready),
      .metric    (metric_ff),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   vse_datapath #(
      .MAX_LEN   (MAX_LEN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .elem_a      (req_payload.elem_a),
      .elem_b      (req_payload.elem_b),
      .metric      (metric_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // Input and output never both open in one cycle
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid together");

   // A last beat closes the input until the result beat goes out
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.last_pair) |=> !req_ready)
      else $error("input open after last beat");

   // Zero-norm flag only with the cosine metric
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.zero_norm) |-> (metric_ff == METRIC_COSINE))
      else $error("zero_norm outside cosine");

endmodule
`default_nettype wire

/* tb/vector_similarity_engine_top_tb.sv */
// Self-checking testbench for the vector similarity engine top level.
`timescale 1ns / 1ps
`default_nettype none
// Pairs are queued by the stimulus process, offered by a clocked driver and
// folded into a local copy of the running sums when each beat is accepted.
// A result beat is predicted on each last_pair. A clocked monitor takes result
// beats under random back-pressure and compares each field with the oldest
// prediction. The metric register is rewritten only once the engine is idle,
// with all four codes and every extreme covered. One long vector runs past
// MAX_LEN with extreme elements, which saturates the dot sum and raises
// too_long.
module vector_similarity_engine_top_tb;
   import vse_pkg::*;

   localparam int MaxLen     = MaxLenDefault;
   localparam int DrainWait  = 120;       // longer than the cosine root and divide
   localparam int CycleLimit = 1500000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [1:0]      csr_write_data = '0;

   // Pairs waiting to be offered, and result beats still owed by the engine
   req_payload_type pair_q[$];
   rsp_payload_type owed_q[$];

   // Local copy of the engine's sums and metric
   logic [41:0] dot_acc;
   logic [41:0] diff_acc;
   logic [40:0] norm_a_acc;
   logic [40:0] norm_b_acc;
   int          pairs_seen;
   bit          dropped_pairs;
   logic [1:0]  metric_now;

   int  errors;
   int  cycles;
   int  send_gap;
   int  recv_stall;
   int  recv_hold;              // long hold-off set by the stimulus process
   bit  send_gaps_on;
   bit  recv_stalls_on;

   vector_similarity_engine_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Bit-pair integer square root, floor
   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Folds one accepted pair into the sums; returns 1 with the result beat
   // when the pair closes the vector.
   function automatic bit fold_pair(input req_payload_type p, output rsp_payload_type r);
      longint          a;
      longint          b;
      longint          v;
      longint          dot;
      longint unsigned mag;
      longint unsigned den;
      longint unsigned q;
      bit              zero;
      a    = longint'(p.elem_a);
      b    = longint'(p.elem_b);
      v    = 0;
      zero = 1'b0;
      r    = '0;
      if (pairs_seen < MaxLen) begin
         dot_acc    = dot_acc + 42'(a * b);
         diff_acc   = diff_acc + 42'((a - b) * (a - b));
         norm_a_acc = norm_a_acc + 41'(a * a);
         norm_b_acc = norm_b_acc + 41'(b * b);
         pairs_seen++;
      end else begin
         dropped_pairs = 1'b1;
      end
      if (!p.last_pair) return 1'b0;
      dot = longint'($signed(dot_acc));
      case (metric_now)
         METRIC_DOT: begin
            v = dot;
            if (v > (64'sd1 <<< 40) - 1) v = (64'sd1 <<< 40) - 1;
            if (v < -(64'sd1 <<< 40)) v = -(64'sd1 <<< 40);
         end
         METRIC_EUCLID: v = longint'(int_root(64'(diff_acc)));
         METRIC_COSINE: begin
            if (norm_a_acc == 0 || norm_b_acc == 0) begin
               zero = 1'b1;
            end else begin
               den = int_root(64'(norm_a_acc)) * int_root(64'(norm_b_acc));
               mag = dot < 0 ? longint'(-dot) : longint'(dot);
               q   = (mag << 15) / den;
               if (dot < 0) v = q > 32768 ? -32768 : -longint'(q);
               else         v = q > 32767 ? 32767 : longint'(q);
            end
         end
         default: v = 0;
      endcase
      r.value     = 41'(v);
      r.zero_norm = zero;
      r.too_long  = dropped_pairs;
      dot_acc       = '0;
      diff_acc      = '0;
      norm_a_acc    = '0;
      norm_b_acc    = '0;
      pairs_seen    = 0;
      dropped_pairs = 1'b0;
      return 1'b1;
   endfunction

   function automatic int draw_wait(bit enabled);
      if (!enabled || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // Driver: offers the head of the pair queue, predicts on acceptance
   always @(posedge clock) begin
      rsp_payload_type r;
      logic            next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            if (fold_pair(req_payload, r)) owed_q.push_back(r);
            void'(pair_q.pop_front());
            next_valid = 1'b0;
            send_gap   = draw_wait(send_gaps_on);
         end else if (!req_valid && send_gap > 0) begin
            send_gap = send_gap - 1;
         end
         if (!next_valid && send_gap == 0 && pair_q.size() != 0) begin
            next_valid = 1'b1;
            req_payload <= pair_q[0];
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: back-pressure on the result side and field-by-field checks
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected result beat, actual %p", $time, rsp_payload);
               errors++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_payload.value !== want.value) begin
                  $display("%0t: value expected %0d actual %0d", $time,
                           $signed(want.value), $signed(rsp_payload.value));
                  errors++;
               end
               if (rsp_payload.zero_norm !== want.zero_norm) begin
                  $display("%0t: zero_norm expected %0b actual %0b", $time,
                           want.zero_norm, rsp_payload.zero_norm);
                  errors++;
               end
               if (rsp_payload.too_long !== want.too_long) begin
                  $display("%0t: too_long expected %0b actual %0b", $time,
                           want.too_long, rsp_payload.too_long);
                  errors++;
               end
            end
            recv_stall = draw_wait(recv_stalls_on);
         end
         if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic add_pair(input int a, input int b, input bit last);
      req_payload_type p;
      p.elem_a    = 16'(a);
      p.elem_b    = 16'(b);
      p.last_pair = last;
      pair_q.push_back(p);
   endtask

   // Sender pauses until every owed beat is back and the engine has settled
   task automatic wait_idle();
      while (pair_q.size() != 0 || req_valid || owed_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic set_metric(input logic [1:0] m);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      metric_now = m;
   endtask

   function automatic int pick_elem();
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   task automatic add_vector(input int len);
      for (int i = 0; i < len; i++) add_pair(pick_elem(), pick_elem(), i == len - 1);
   endtask

   initial begin
      logic [1:0] m;
      errors         = 0;
      cycles         = 0;
      recv_hold      = 0;
      send_gaps_on   = 1'b1;
      recv_stalls_on = 1'b1;
      dot_acc        = '0;
      diff_acc       = '0;
      norm_a_acc     = '0;
      norm_b_acc     = '0;
      pairs_seen     = 0;
      dropped_pairs  = 1'b0;
      metric_now     = METRIC_DOT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes per metric, zero norms, cosine clamps, unused code
      set_metric(METRIC_DOT);
      add_pair(-32768, -32768, 1'b1);
      add_pair(32767, -32768, 1'b0);
      add_pair(-32768, 32767, 1'b1);
      add_pair(0, 0, 1'b1);
      set_metric(METRIC_EUCLID);
      add_pair(32767, -32768, 1'b1);
      add_pair(0, 0, 1'b1);
      add_pair(-32768, 32767, 1'b0);
      add_pair(12345, -7, 1'b1);
      set_metric(METRIC_COSINE);
      add_pair(0, 5, 1'b1);
      add_pair(7, 0, 1'b1);
      add_pair(0, 0, 1'b1);
      add_pair(-32768, 32767, 1'b1);
      add_pair(-32768, -32768, 1'b1);
      add_pair(3, 4, 1'b0);
      add_pair(-4, 3, 1'b1);
      set_metric(METRIC_UNUSED);
      add_pair(100, 200, 1'b1);
      add_pair(-32768, 32767, 1'b1);

      // Past MAX_LEN with extreme pairs: dot saturates and too_long is raised
      set_metric(METRIC_DOT);
      for (int i = 0; i < MaxLen + 3; i++) add_pair(-32768, -32768, i == MaxLen + 2);
      set_metric(METRIC_DOT);

      // Random short vectors, metric changed between phases
      for (int ph = 0; ph < 12; ph++) begin
         m = ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3));
         set_metric(m);
         send_gaps_on   = ph % 3 != 1;
         recv_stalls_on = ph % 4 != 2;
         if (ph == 5) recv_hold = 400;   // result side holds off, engine backs up
         for (int v = 0; v < 2; v++) add_vector($urandom_range(1, 4));
      end

      wait_idle();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
src/vse_pkg.sv
src/vse_ctrl.sv
src/vse_datapath.sv
src/vector_similarity_engine_top.sv
tb/vector_similarity_engine_top_tb.sv
